FILE: sv/box_average_edge_replicated_macros.svh
// assertion macros for the box average filter
`ifndef BOX_AVERAGE_EDGE_REPLICATED_MACROS_SVH
`define BOX_AVERAGE_EDGE_REPLICATED_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition must hold at every clock edge out of reset
`define BAE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// antecedent in this cycle implies consequent in the next one
`define BAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BAE_ASSERT_ALWAYS(label, cond)
`define BAE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/bae_pkg.sv
// shared types and constants of the box average filter
package bae_pkg;

  localparam int MAX_RADIUS = 7;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int SMP_W      = 8;
  localparam int SMP_MAX    = (1 << SMP_W) - 1;
  localparam int RAD_W      = 3;
  localparam int D_W        = RAD_W + 1;
  localparam int Q_W        = 5;
  localparam int RECIP_W    = 16;
  localparam int IDX_W      = $clog2(WIN_DEPTH);
  localparam int SEEN_W     = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W      = $clog2(WIN_DEPTH * SMP_MAX + 1);
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int PROD_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MODE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RECIPROCAL = CFG_IDX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_ROUND,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL,
    OP_ROUND
  } op_e;

  typedef struct packed {
    logic              in_ready;
    op_e               op;
    logic [IDX_W-1:0]  tap_idx;
    logic              emit;
    logic              emit_last;
  } ctrl_t;

endpackage

FILE: sv/bae_window.sv
// sample shift line with one selectable read tap
module bae_window (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [bae_pkg::SMP_W-1:0]     sample_i,
  input  logic [bae_pkg::IDX_W-1:0]     tap_idx_i,
  output logic [bae_pkg::SMP_W-1:0]     tap_o
);

  logic [bae_pkg::SMP_W-1:0] store_q [bae_pkg::WIN_DEPTH];

  // newest sample at index 0
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      store_q[0] <= sample_i;
      for (int k = 1; k < bae_pkg::WIN_DEPTH; k++) begin
        store_q[k] <= store_q[k-1];
      end
    end
  end

  assign tap_o = store_q[tap_idx_i];

endmodule

FILE: sv/bae_arith.sv
// shared arithmetic unit: window accumulate, restoring divide, reciprocal multiply, rounding shift
module bae_arith (
  input  logic                            clk_i,
  input  bae_pkg::op_e                    op_i,
  input  logic [bae_pkg::SMP_W-1:0]       tap_i,
  input  logic [bae_pkg::RAD_W-1:0]       radius_i,
  input  logic                            norm_mode_i,
  input  logic [bae_pkg::Q_W-1:0]         frac_bits_i,
  input  logic [bae_pkg::RECIP_W-1:0]     reciprocal_i,
  output logic [bae_pkg::SMP_W-1:0]       result_o
);

  logic [bae_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [bae_pkg::SUM_W-1:0]  quo_q, quo_d;
  logic [bae_pkg::D_W-1:0]    rem_q, rem_d;
  logic [bae_pkg::PROD_W-1:0] prod_q, prod_d;

  logic [bae_pkg::D_W-1:0]    divisor;
  logic [bae_pkg::D_W:0]      rem_sh;
  logic                       fits;
  logic [bae_pkg::PROD_W-1:0] rnd;
  logic [bae_pkg::PROD_W-1:0] rsum;

  assign divisor = bae_pkg::D_W'({radius_i, 1'b1});
  assign rem_sh  = {rem_q, quo_q[bae_pkg::SUM_W-1]};
  assign fits    = rem_sh >= (bae_pkg::D_W + 1)'(divisor);
  assign rnd     = (frac_bits_i == '0) ? '0
                 : bae_pkg::PROD_W'(1) << (frac_bits_i - bae_pkg::Q_W'(1));
  assign rsum    = prod_q + rnd;

  always_comb begin
    sum_d  = sum_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    prod_d = prod_q;
    case (op_i)
      bae_pkg::OP_CLEAR:    sum_d = '0;
      bae_pkg::OP_ACCUM:    sum_d = sum_q + bae_pkg::SUM_W'(tap_i);
      bae_pkg::OP_DIV_INIT: begin
        // half the diameter is the radius
        quo_d = sum_q + bae_pkg::SUM_W'(radius_i);
        rem_d = '0;
      end
      bae_pkg::OP_DIV_STEP: begin
        quo_d = {quo_q[bae_pkg::SUM_W-2:0], fits};
        rem_d = fits ? bae_pkg::D_W'(rem_sh - (bae_pkg::D_W + 1)'(divisor))
                     : bae_pkg::D_W'(rem_sh);
      end
      bae_pkg::OP_MUL:      prod_d = bae_pkg::PROD_W'(reciprocal_i)
                                   * bae_pkg::PROD_W'(sum_q);
      bae_pkg::OP_ROUND:    prod_d = rsum >> frac_bits_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

  // saturate to one byte
  always_comb begin
    if (norm_mode_i) begin
      result_o = (prod_q > bae_pkg::PROD_W'(bae_pkg::SMP_MAX))
               ? bae_pkg::SMP_W'(bae_pkg::SMP_MAX) : prod_q[bae_pkg::SMP_W-1:0];
    end else begin
      result_o = (quo_q > bae_pkg::SUM_W'(bae_pkg::SMP_MAX))
               ? bae_pkg::SMP_W'(bae_pkg::SMP_MAX) : quo_q[bae_pkg::SMP_W-1:0];
    end
  end

endmodule

FILE: sv/bae_ctrl.sv
// sequencer: line position tracking, tap walk and normalize steps
module bae_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  input  logic                        out_free_i,
  input  logic [bae_pkg::RAD_W-1:0]   radius_i,
  input  logic                        norm_mode_i,
  output bae_pkg::ctrl_t              ctrl_o
);

  bae_pkg::state_e state_q, state_d;
  logic [bae_pkg::RAD_W-1:0]  e_q, e_d;
  logic [bae_pkg::IDX_W-1:0]  j_q, j_d;
  logic [bae_pkg::STEP_W-1:0] step_q, step_d;
  logic [bae_pkg::SEEN_W-1:0] seen_q, seen_d;
  logic                       last_q, last_d;

  logic                       accept;
  logic [bae_pkg::SEEN_W-1:0] seen_inc;
  logic [bae_pkg::SEEN_W-1:0] top_start;
  logic [bae_pkg::RAD_W-1:0]  e_start;
  logic                       has_out;
  logic [bae_pkg::IDX_W-1:0]  j_max;
  logic                       sum_done;
  logic                       div_done;
  logic                       more;
  logic signed [bae_pkg::IDX_W:0] p_s;
  logic [bae_pkg::IDX_W-1:0]  top;

  assign accept    = (state_q == bae_pkg::ST_IDLE) && in_valid_i;
  assign seen_inc  = (seen_q == bae_pkg::SEEN_W'(bae_pkg::WIN_DEPTH))
                   ? seen_q : seen_q + bae_pkg::SEEN_W'(1);
  assign top_start = seen_inc - bae_pkg::SEEN_W'(1);
  assign e_start   = (top_start > bae_pkg::SEEN_W'(radius_i))
                   ? radius_i : bae_pkg::RAD_W'(top_start);
  assign has_out   = in_last_i
                   || (seen_inc >= bae_pkg::SEEN_W'(radius_i) + bae_pkg::SEEN_W'(1));
  assign j_max     = bae_pkg::IDX_W'({radius_i, 1'b0});
  assign sum_done  = j_q == j_max;
  assign div_done  = step_q == bae_pkg::STEP_W'(bae_pkg::SUM_W - 1);
  assign more      = last_q && (e_q != '0);

  // tap position, clamped to the samples of this line
  assign p_s = $signed({1'b0, bae_pkg::IDX_W'(e_q)})
             + $signed({1'b0, bae_pkg::IDX_W'(radius_i)})
             - $signed({1'b0, j_q});
  assign top = bae_pkg::IDX_W'(seen_q - bae_pkg::SEEN_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      bae_pkg::ST_IDLE:  if (accept && has_out) state_d = bae_pkg::ST_SUM;
      bae_pkg::ST_SUM:   if (sum_done) state_d = bae_pkg::ST_PREP;
      bae_pkg::ST_PREP:  state_d = norm_mode_i ? bae_pkg::ST_ROUND : bae_pkg::ST_DIV;
      bae_pkg::ST_DIV:   if (div_done) state_d = bae_pkg::ST_EMIT;
      bae_pkg::ST_ROUND: state_d = bae_pkg::ST_EMIT;
      bae_pkg::ST_EMIT: begin
        if (out_free_i) state_d = more ? bae_pkg::ST_SUM : bae_pkg::ST_IDLE;
      end
      default:           state_d = bae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    e_d    = e_q;
    j_d    = j_q;
    step_d = step_q;
    seen_d = seen_q;
    last_d = last_q;
    case (state_q)
      bae_pkg::ST_IDLE: begin
        if (accept) begin
          seen_d = seen_inc;
          last_d = in_last_i;
          e_d    = in_last_i ? e_start : radius_i;
          j_d    = '0;
        end
      end
      bae_pkg::ST_SUM:  j_d = j_q + bae_pkg::IDX_W'(1);
      bae_pkg::ST_PREP: step_d = '0;
      bae_pkg::ST_DIV:  step_d = step_q + bae_pkg::STEP_W'(1);
      bae_pkg::ST_EMIT: begin
        if (out_free_i) begin
          if (more) begin
            e_d = e_q - bae_pkg::RAD_W'(1);
            j_d = '0;
          end else if (last_q) begin
            seen_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl_o.in_ready  = state_q == bae_pkg::ST_IDLE;
    ctrl_o.emit      = (state_q == bae_pkg::ST_EMIT) && out_free_i;
    ctrl_o.emit_last = last_q && (e_q == '0);
    if (p_s < 0) begin
      ctrl_o.tap_idx = '0;
    end else if (p_s[bae_pkg::IDX_W-1:0] > top) begin
      ctrl_o.tap_idx = top;
    end else begin
      ctrl_o.tap_idx = p_s[bae_pkg::IDX_W-1:0];
    end
    case (state_q)
      bae_pkg::ST_IDLE:  ctrl_o.op = accept ? bae_pkg::OP_CLEAR : bae_pkg::OP_NONE;
      bae_pkg::ST_SUM:   ctrl_o.op = bae_pkg::OP_ACCUM;
      bae_pkg::ST_PREP:  ctrl_o.op = norm_mode_i ? bae_pkg::OP_MUL : bae_pkg::OP_DIV_INIT;
      bae_pkg::ST_DIV:   ctrl_o.op = bae_pkg::OP_DIV_STEP;
      bae_pkg::ST_ROUND: ctrl_o.op = bae_pkg::OP_ROUND;
      bae_pkg::ST_EMIT:  ctrl_o.op = (out_free_i && more) ? bae_pkg::OP_CLEAR
                                                          : bae_pkg::OP_NONE;
      default:           ctrl_o.op = bae_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bae_pkg::ST_IDLE;
      e_q     <= '0;
      j_q     <= '0;
      step_q  <= '0;
      seen_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      e_q     <= e_d;
      j_q     <= j_d;
      step_q  <= step_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
    end
  end

endmodule

FILE: sv/box_average_edge_replicated.sv
// top level of the edge-replicated box average filter
// Smooths a line of 8-bit samples with a window of 2*radius+1 samples, the line
// edges extended by repeating the first and last sample. Results lag the input
// by radius positions; the item flagged tlast flushes the remaining positions,
// so one input item yields zero to radius+1 result items, the final one flagged
// tlast. Every result is built by one shared arithmetic unit under a small
// sequencer: a walk over the 2*radius+1 window taps builds the sum, a prepare
// step starts normalization, then either restoring division, one quotient bit
// per cycle (mode 0), or a rounding shift after the multiply (mode 1), and a
// final step hands the result to the output register. s_axis_tready is low
// while a result is in progress; the output register lets the next item in
// while the last result still waits. Configuration writes are accepted in any
// cycle and must only be issued while the block is idle.
`include "box_average_edge_replicated_macros.svh"

module box_average_edge_replicated (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] sample
  input  logic                             s_axis_tlast,   // last_in
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // [7:0] smoothed
  output logic                             m_axis_tlast,   // last_out
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bae_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bae_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // configuration registers
  logic [bae_pkg::RAD_W-1:0]   radius_q;
  logic                        norm_mode_q;
  logic [bae_pkg::Q_W-1:0]     frac_bits_q;
  logic [bae_pkg::RECIP_W-1:0] reciprocal_q;
  logic [bae_pkg::RAD_W-1:0]   radius_eff;

  // output register
  logic                        out_valid_q;
  logic [bae_pkg::SMP_W-1:0]   out_data_q;
  logic                        out_last_q;
  logic                        out_free;

  bae_pkg::ctrl_t              ctrl;
  logic [bae_pkg::SMP_W-1:0]   tap;
  logic [bae_pkg::SMP_W-1:0]   result;
  logic                        in_accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= bae_pkg::RAD_W'(1);
      norm_mode_q  <= 1'b0;
      frac_bits_q  <= bae_pkg::Q_W'(8);
      reciprocal_q <= bae_pkg::RECIP_W'(85);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bae_pkg::CFG_RADIUS:     radius_q     <= cfg_data_i[bae_pkg::RAD_W-1:0];
        bae_pkg::CFG_NORM_MODE:  norm_mode_q  <= cfg_data_i[0];
        bae_pkg::CFG_FRAC_BITS:  frac_bits_q  <= cfg_data_i[bae_pkg::Q_W-1:0];
        bae_pkg::CFG_RECIPROCAL: reciprocal_q <= cfg_data_i[bae_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // radius beyond the window capacity acts as the largest one
  assign radius_eff = (int'(radius_q) > bae_pkg::MAX_RADIUS)
                    ? bae_pkg::RAD_W'(bae_pkg::MAX_RADIUS) : radius_q;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  bae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .out_free_i  (out_free),
    .radius_i    (radius_eff),
    .norm_mode_i (norm_mode_q),
    .ctrl_o      (ctrl)
  );

  bae_window u_window (
    .clk_i     (clk_i),
    .shift_i   (in_accept),
    .sample_i  (s_axis_tdata),
    .tap_idx_i (ctrl.tap_idx),
    .tap_o     (tap)
  );

  bae_arith u_arith (
    .clk_i        (clk_i),
    .op_i         (ctrl.op),
    .tap_i        (tap),
    .radius_i     (radius_eff),
    .norm_mode_i  (norm_mode_q),
    .frac_bits_i  (frac_bits_q),
    .reciprocal_i (reciprocal_q),
    .result_o     (result)
  );

  assign s_axis_tready = ctrl.in_ready;

  // result holding stage, decouples the sequencer from the downstream stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= result;
      out_last_q <= ctrl.emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // the sequencer never overwrites a result that is still waiting
  `BAE_ASSERT_ALWAYS(a_no_overwrite, !ctrl.emit || !out_valid_q || m_axis_tready)
  // a line end always produces at least one result, so the block goes busy
  `BAE_ASSERT_NEXT(a_last_busy, in_accept && s_axis_tlast, !s_axis_tready)
  // no new item is taken while a result is being computed
  `BAE_ASSERT_ALWAYS(a_ready_no_op, !s_axis_tready || !ctrl.emit)

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the edge-replicated box average filter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // run limits: a quiet stretch of this length lets any result still in the works
  // come out
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    logic [7:0] smoothed;
    logic       last;
  } smooth_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input stream, driven at the rising edge
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] sample
  logic                  s_axis_tlast = 1'b0; // last_in

  // result stream
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [7:0] smoothed
  logic                  m_axis_tlast;        // last_out

  // register writes
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [bae_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bae_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // mirror of the registers as the block should hold them
  logic [2:0]  radius_reg   = 3'd1;
  logic        mode_reg     = 1'b0;
  logic [4:0]  frac_reg     = 5'd8;
  logic [15:0] recip_reg    = 16'd85;

  // mirror of the sample history, newest first, and the line position count
  logic [7:0]  line_history [bae_pkg::WIN_DEPTH];
  int          line_seen = 0;

  // averages predicted for accepted samples, oldest first
  smooth_result_t expected_averages [$];
  smooth_result_t oldest_average;

  int failures = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  box_average_edge_replicated uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // cycle watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d averages outstanding", $time,
               expected_averages.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker: every accepted item against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual smoothed %0d last %0d",
                 $time, m_axis_tdata, m_axis_tlast);
        failures++;
      end else begin
        oldest_average = expected_averages.pop_front();
        if (m_axis_tdata !== oldest_average.smoothed) begin
          $display("%0t: smoothed expected %0d actual %0d", $time,
                   oldest_average.smoothed, m_axis_tdata);
          failures++;
        end
        if (m_axis_tlast !== oldest_average.last) begin
          $display("%0t: last expected %0d actual %0d", $time,
                   oldest_average.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  // sum of the window centered pos positions behind the newest sample,
  // edge positions replicated
  function automatic int window_sum_at(input int pos, input int rad);
    int acc;
    int p;
    acc = 0;
    for (int t = -rad; t <= rad; t++) begin
      p = pos - t;
      if (p > line_seen - 1) p = line_seen - 1;
      if (p < 0) p = 0;
      if (p > bae_pkg::WIN_DEPTH - 1) p = bae_pkg::WIN_DEPTH - 1;
      acc += line_history[p];
    end
    return acc;
  endfunction

  // normalization of a window sum in the current mode, saturating at 255
  function automatic logic [7:0] normalize_sum(input int sum, input int rad);
    longint unsigned v;
    longint unsigned dia;
    if (!mode_reg) begin
      dia = 64'(2 * rad + 1);
      v = (64'(sum) + dia / 2) / dia;
    end else begin
      v = 64'(recip_reg) * 64'(sum);
      if (frac_reg != 0) v += 64'd1 << (frac_reg - 1);
      v = v >> frac_reg;
    end
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // one accepted sample: update the history and queue the averages it releases
  function automatic void predict_averages(input logic [7:0] sample, input logic last_flag);
    int rad;
    int top;
    rad = int'(radius_reg);
    if (rad > bae_pkg::MAX_RADIUS) rad = bae_pkg::MAX_RADIUS;
    for (int k = bae_pkg::WIN_DEPTH - 1; k > 0; k--) line_history[k] = line_history[k-1];
    line_history[0] = sample;
    if (line_seen < bae_pkg::WIN_DEPTH) line_seen++;
    if (!last_flag) begin
      if (line_seen >= rad + 1)
        expected_averages.push_back('{normalize_sum(window_sum_at(rad, rad), rad), 1'b0});
    end else begin
      // flush the rest of the line, the final position flagged
      top = line_seen - 1;
      if (top > rad) top = rad;
      for (int e = top; e >= 0; e--)
        expected_averages.push_back('{normalize_sum(window_sum_at(e, rad), rad),
                                      logic'(e == 0)});
      line_seen = 0;
    end
  endfunction

  // one sample through the input stream, with random idle gaps ahead of it
  task automatic send_sample(input logic [7:0] sample, input logic last_flag);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tlast  <= last_flag;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_averages(sample, last_flag);
  endtask

  // wait for every pending average, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // single register write; valid stays up for a following write
  task automatic write_reg(input logic [bae_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bae_pkg::CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bae_pkg::CFG_RADIUS:     radius_reg = value[2:0];
      bae_pkg::CFG_NORM_MODE:  mode_reg   = value[0];
      bae_pkg::CFG_FRAC_BITS:  frac_reg   = value[4:0];
      bae_pkg::CFG_RECIPROCAL: recip_reg  = value;
      default: ;
    endcase
  endtask

  // all four registers; unused upper data bits carry random junk
  task automatic configure(input int rad, input bit mode, input int q, input int recip);
    write_reg(bae_pkg::CFG_RADIUS,     (16'($urandom) & 16'hFFF8) | 16'(rad));
    write_reg(bae_pkg::CFG_NORM_MODE,  (16'($urandom) & 16'hFFFE) | 16'(mode));
    write_reg(bae_pkg::CFG_FRAC_BITS,  (16'($urandom) & 16'hFFE0) | 16'(q));
    write_reg(bae_pkg::CFG_RECIPROCAL, 16'(recip));
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a matching reciprocal, sometimes odd shifts or a random one
  task automatic configure_random(input int rad, input bit mode);
    int q;
    int recip;
    case ($urandom_range(0, 9))
      0: q = 0;
      1: q = $urandom_range(17, 31);
      default: q = $urandom_range(1, 16);
    endcase
    if (q > 16 || $urandom_range(0, 7) == 0) begin
      recip = $urandom_range(0, 65535);
    end else begin
      recip = (1 << q) / (2 * rad + 1);
      if (recip > 65535) recip = 65535;
    end
    configure(rad, mode, q, recip);
  endtask

  function automatic logic [7:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // reset values: radius 1, rounded division
  task automatic test_default_registers();
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b1);
    settle();
  endtask

  // lines no longer than the radius give all their averages at the end
  task automatic test_short_lines();
    configure(3, 1'b0, 8, 85);
    send_sample(8'd255, 1'b1);
    send_sample(8'd17, 1'b0);
    send_sample(8'd200, 1'b1);
    settle();
  endtask

  // diameter one passes the samples through
  task automatic test_radius_zero();
    configure(0, 1'b0, 8, 85);
    send_sample(8'd128, 1'b0);
    send_sample(8'd1, 1'b1);
    settle();
  endtask

  // widest window, flush of radius+1 averages
  task automatic test_widest_window();
    configure(7, 1'b0, 8, 17);
    for (int i = 0; i < 8; i++)
      send_sample((i % 2 == 0) ? 8'd255 : 8'd0, logic'(i == 7));
    settle();
  endtask

  // radius raised in the middle of a line
  task automatic test_radius_change_mid_line();
    configure(1, 1'b0, 8, 85);
    send_sample(8'd40, 1'b0);
    send_sample(8'd90, 1'b0);
    settle();
    configure(4, 1'b0, 8, 85);
    send_sample(8'd250, 1'b0);
    send_sample(8'd3, 1'b1);
    settle();
  endtask

  // reciprocal mode: no shift, then a huge reciprocal that saturates
  task automatic test_reciprocal_extremes();
    configure(1, 1'b1, 0, 1);
    send_sample(8'd10, 1'b0);
    send_sample(8'd20, 1'b1);
    settle();
    configure(2, 1'b1, 1, 65535);
    send_sample(8'd255, 1'b0);
    send_sample(8'd1, 1'b1);
    settle();
  endtask

  // random whole lines under one idling pattern; radius and mode sometimes change
  // between lines, and the radius now and then inside one
  task automatic test_random_lines(input int items, input int rad, input bit mode,
                                   input int send_pct, input int recv_pct);
    int sent;
    int len;
    int split;
    settle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    configure_random(rad, mode);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 5) == 0) begin
        settle();
        configure_random($urandom_range(0, 7), 1'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 9))
        0, 1: len = $urandom_range(1, (radius_reg == 0) ? 1 : int'(radius_reg));
        9: len = $urandom_range(21, 40);
        default: len = $urandom_range(2, 20);
      endcase
      split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int i = 0; i < len; i++) begin
        if (split != 0 && i == split) begin
          settle();
          configure_random($urandom_range(0, 7), mode_reg);
        end
        send_sample(random_sample(), logic'(i == len - 1));
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    for (int k = 0; k < bae_pkg::WIN_DEPTH; k++) line_history[k] = 8'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_registers();
    test_short_lines();
    test_radius_zero();
    test_widest_window();
    test_radius_change_mid_line();
    test_reciprocal_extremes();

    test_random_lines(56, 7, 1'b0, 0, 0);
    test_random_lines(56, 0, 1'b1, 85, 0);
    test_random_lines(56, 3, 1'b0, 0, 85);
    test_random_lines(56, 5, 1'b1, 6, 6);
    test_random_lines(56, $urandom_range(0, 7), 1'($urandom_range(0, 1)), 0, 0);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
